// ===== design/spc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spc_pkg - shared types and constants for the sprite collision block
// Command format between front and back, result format, register indexes.
// ----------------------------------------------------------------------------
package spc_pkg;

  // signed width of box corners in common space
  localparam int unsigned CRD_W = 18;
  // width of local coordinates, overlap sizes and row counts (up to 127)
  localparam int unsigned LOC_W = 7;
  // input field widths
  localparam int unsigned ROW_IDX_W = 4;
  localparam int unsigned ROW_BITS_W = 16;
  localparam int unsigned POS_W = 16;
  localparam int unsigned ORG_W = 4;
  localparam int unsigned SIZE_W = 5;
  // result field widths
  localparam int unsigned COUNT_W = 9;
  localparam int unsigned COORD_W = 4;
  // command queue depth
  localparam int unsigned QDEPTH = 2;

  localparam logic [SIZE_W-1:0] SIZE_RESET = 5'd16;
  localparam logic [ORG_W-1:0] ORG_RESET = 4'd0;

  // configuration register indexes
  typedef enum logic [2:0] {
    REG_A_ORG_X = 3'd0,
    REG_A_ORG_Y = 3'd1,
    REG_B_ORG_X = 3'd2,
    REG_B_ORG_Y = 3'd3,
    REG_A_WIDTH = 3'd4,
    REG_A_HEIGHT = 3'd5,
    REG_B_WIDTH = 3'd6,
    REG_B_HEIGHT = 3'd7
  } spc_reg_e;

  // operation codes
  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_QUERY = 1'b1
  } spc_op_e;

  // mask select codes
  typedef enum logic {
    SEL_A = 1'b0,
    SEL_B = 1'b1
  } spc_sel_e;

  // back end sequencer states
  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_SCAN = 2'd1,
    ST_DONE = 2'd2
  } spc_state_e;

  // classified command handed from front to back
  typedef struct packed {
    spc_op_e op;
    spc_sel_e sel;
    logic [ROW_IDX_W-1:0] row;
    logic [ROW_BITS_W-1:0] bits;
    logic touch;
    logic [LOC_W-1:0] a_col;
    logic [LOC_W-1:0] a_row;
    logic [LOC_W-1:0] b_col;
    logic [LOC_W-1:0] b_row;
    logic [LOC_W-1:0] n_cols;
    logic [LOC_W-1:0] n_rows;
  } spc_cmd_t;

  // one query result
  typedef struct packed {
    logic [COORD_W-1:0] first_b_row;
    logic [COORD_W-1:0] first_b_col;
    logic [COORD_W-1:0] first_a_row;
    logic [COORD_W-1:0] first_a_col;
    logic [COUNT_W-1:0] hit_count;
    logic bounds_touch;
    logic is_collision;
  } spc_res_t;

  // back end control strobes
  typedef struct packed {
    logic pop;
    logic mask_we;
    logic start;
    logic step;
    logic emit;
  } spc_ctl_t;

endpackage

// ===== design/spc_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spc_front - input stage and classifier
// Holds the configuration registers, registers each accepted transaction with
// its box corners, then turns it into a command with overlap start and size.
// ----------------------------------------------------------------------------
module spc_front #(
  parameter int unsigned SPRITE_SIZE = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic cfg_we_i,
  input  logic [2:0] cfg_idx_i,
  input  logic [spc_pkg::SIZE_W-1:0] cfg_data_i,
  input  logic s_tvalid_i,
  output logic s_tready_o,
  input  logic [87:0] s_tdata_i,
  input  logic [1:0] s_tuser_i,
  output logic cmd_valid_o,
  input  logic cmd_ready_i,
  output spc_pkg::spc_cmd_t cmd_o
);

  localparam int unsigned CRD_W = spc_pkg::CRD_W;
  localparam int unsigned LOC_W = spc_pkg::LOC_W;
  localparam int unsigned ORG_W = spc_pkg::ORG_W;
  localparam int unsigned SIZE_W = spc_pkg::SIZE_W;
  localparam int unsigned POS_W = spc_pkg::POS_W;
  localparam logic [LOC_W-1:0] SIZE_MAX = LOC_W'(SPRITE_SIZE);
  localparam logic signed [CRD_W-1:0] ONE = CRD_W'(1);

  // configuration registers
  logic [ORG_W-1:0] a_org_x_q, a_org_y_q, b_org_x_q, b_org_y_q;
  logic [SIZE_W-1:0] a_w_q, a_h_q, b_w_q, b_h_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_org_x_q <= spc_pkg::ORG_RESET;
      a_org_y_q <= spc_pkg::ORG_RESET;
      b_org_x_q <= spc_pkg::ORG_RESET;
      b_org_y_q <= spc_pkg::ORG_RESET;
      a_w_q <= spc_pkg::SIZE_RESET;
      a_h_q <= spc_pkg::SIZE_RESET;
      b_w_q <= spc_pkg::SIZE_RESET;
      b_h_q <= spc_pkg::SIZE_RESET;
    end else if (cfg_we_i) begin
      case (spc_pkg::spc_reg_e'(cfg_idx_i))
        spc_pkg::REG_A_ORG_X: a_org_x_q <= cfg_data_i[ORG_W-1:0];
        spc_pkg::REG_A_ORG_Y: a_org_y_q <= cfg_data_i[ORG_W-1:0];
        spc_pkg::REG_B_ORG_X: b_org_x_q <= cfg_data_i[ORG_W-1:0];
        spc_pkg::REG_B_ORG_Y: b_org_y_q <= cfg_data_i[ORG_W-1:0];
        spc_pkg::REG_A_WIDTH: a_w_q <= cfg_data_i;
        spc_pkg::REG_A_HEIGHT: a_h_q <= cfg_data_i;
        spc_pkg::REG_B_WIDTH: b_w_q <= cfg_data_i;
        spc_pkg::REG_B_HEIGHT: b_h_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // zero reads as one, above the sprite size saturates
  function automatic logic signed [CRD_W-1:0] clamp_size(input logic [SIZE_W-1:0] v);
    logic [LOC_W-1:0] s;
    s = LOC_W'(v);
    if (v == '0) begin
      s = LOC_W'(1);
    end else if (s > SIZE_MAX) begin
      s = SIZE_MAX;
    end
    return {{(CRD_W-LOC_W){1'b0}}, s};
  endfunction

  function automatic logic signed [CRD_W-1:0] sext_pos(input logic [POS_W-1:0] p);
    return {{(CRD_W-POS_W){p[POS_W-1]}}, p};
  endfunction

  function automatic logic signed [CRD_W-1:0] zext_org(input logic [ORG_W-1:0] o);
    return {{(CRD_W-ORG_W){1'b0}}, o};
  endfunction

  // box corners of the incoming transaction
  logic signed [CRD_W-1:0] ax0_d, ax1_d, ay0_d, ay1_d, bx0_d, bx1_d, by0_d, by1_d;

  always_comb begin
    ax0_d = sext_pos(s_tdata_i[35:20]) - zext_org(a_org_x_q);
    ay0_d = sext_pos(s_tdata_i[51:36]) - zext_org(a_org_y_q);
    bx0_d = sext_pos(s_tdata_i[67:52]) - zext_org(b_org_x_q);
    by0_d = sext_pos(s_tdata_i[83:68]) - zext_org(b_org_y_q);
    ax1_d = ax0_d + clamp_size(a_w_q) - ONE;
    ay1_d = ay0_d + clamp_size(a_h_q) - ONE;
    bx1_d = bx0_d + clamp_size(b_w_q) - ONE;
    by1_d = by0_d + clamp_size(b_h_q) - ONE;
  end

  // stage register
  logic s1_valid_q;
  spc_pkg::spc_op_e op_q;
  spc_pkg::spc_sel_e sel_q;
  logic [spc_pkg::ROW_IDX_W-1:0] row_q;
  logic [spc_pkg::ROW_BITS_W-1:0] bits_q;
  logic signed [CRD_W-1:0] ax0_q, ax1_q, ay0_q, ay1_q, bx0_q, bx1_q, by0_q, by1_q;
  logic s_acc;

  assign s_tready_o = !s1_valid_q || cmd_ready_i;
  assign s_acc = s_tvalid_i && s_tready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s_tready_o) begin
      s1_valid_q <= s_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_acc) begin
      op_q <= spc_pkg::spc_op_e'(s_tuser_i[0]);
      sel_q <= spc_pkg::spc_sel_e'(s_tuser_i[1]);
      row_q <= s_tdata_i[3:0];
      bits_q <= s_tdata_i[19:4];
      ax0_q <= ax0_d;
      ax1_q <= ax1_d;
      ay0_q <= ay0_d;
      ay1_q <= ay1_d;
      bx0_q <= bx0_d;
      bx1_q <= bx1_d;
      by0_q <= by0_d;
      by1_q <= by1_d;
    end
  end

  // overlap start in each sprite's local frame and overlap size
  logic signed [CRD_W-1:0] dx, dy, ox0, ox1, oy0, oy1, ow, oh;

  always_comb begin
    dx = ax0_q - bx0_q;
    dy = ay0_q - by0_q;
    ox0 = (ax0_q > bx0_q) ? ax0_q : bx0_q;
    ox1 = (ax1_q < bx1_q) ? ax1_q : bx1_q;
    oy0 = (ay0_q > by0_q) ? ay0_q : by0_q;
    oy1 = (ay1_q < by1_q) ? ay1_q : by1_q;
    ow = ox1 - ox0 + ONE;
    oh = oy1 - oy0 + ONE;

    cmd_o.op = op_q;
    cmd_o.sel = sel_q;
    cmd_o.row = row_q;
    cmd_o.bits = bits_q;
    cmd_o.touch = (ax0_q <= bx1_q) && (ax1_q >= bx0_q) &&
                  (ay0_q <= by1_q) && (ay1_q >= by0_q);
    cmd_o.a_col = dx[CRD_W-1] ? LOC_W'(-dx) : '0;
    cmd_o.b_col = dx[CRD_W-1] ? '0 : LOC_W'(dx);
    cmd_o.a_row = dy[CRD_W-1] ? LOC_W'(-dy) : '0;
    cmd_o.b_row = dy[CRD_W-1] ? '0 : LOC_W'(dy);
    cmd_o.n_cols = LOC_W'(ow);
    cmd_o.n_rows = LOC_W'(oh);
  end

  assign cmd_valid_o = s1_valid_q;

endmodule

// ===== design/spc_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spc_queue - short command queue
// Small FIFO between the classifier and the scan engine.
// ----------------------------------------------------------------------------
module spc_queue (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_valid_i,
  output logic push_ready_o,
  input  spc_pkg::spc_cmd_t push_data_i,
  output logic pop_valid_o,
  input  logic pop_i,
  output spc_pkg::spc_cmd_t pop_data_o
);

  localparam int unsigned DEPTH = spc_pkg::QDEPTH;
  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [CNT_W-1:0] FULL = CNT_W'(DEPTH);
  localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

  spc_pkg::spc_cmd_t mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] cnt_q;
  logic do_push, do_pop;

  assign push_ready_o = (cnt_q != FULL);
  assign pop_valid_o = (cnt_q != '0);
  assign do_push = push_valid_i && push_ready_o;
  assign do_pop = pop_i && pop_valid_o;
  assign pop_data_o = mem_q[rd_ptr_q];

  // storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == LAST) ? '0 : wr_ptr_q + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == LAST) ? '0 : rd_ptr_q + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - CNT_W'(1);
      end
    end
  end

endmodule

// ===== design/spc_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spc_back - mask store and overlap scan engine
// Executes commands: mask row loads, and queries that scan one row pair of
// the overlap per cycle, then hands the result to the output register.
// ----------------------------------------------------------------------------
module spc_back #(
  parameter int unsigned SPRITE_SIZE = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic cmd_valid_i,
  output logic cmd_pop_o,
  input  spc_pkg::spc_cmd_t cmd_i,
  output logic res_valid_o,
  input  logic res_ready_i,
  output spc_pkg::spc_res_t res_o
);

  localparam int unsigned LOC_W = spc_pkg::LOC_W;
  localparam int unsigned COUNT_W = spc_pkg::COUNT_W;
  localparam int unsigned COORD_W = spc_pkg::COORD_W;
  // at most sixteen rows and columns can ever be loaded
  localparam int unsigned MASK_DIM = (SPRITE_SIZE < spc_pkg::ROW_BITS_W) ?
                                     SPRITE_SIZE : spc_pkg::ROW_BITS_W;
  localparam int unsigned IW = $clog2(MASK_DIM);
  localparam int unsigned PC_W = $clog2(MASK_DIM + 1);
  localparam logic [LOC_W-1:0] DIM = LOC_W'(MASK_DIM);
  localparam logic [LOC_W-1:0] LAST_ROW = LOC_W'(MASK_DIM - 1);
  localparam logic [MASK_DIM-1:0] ONE_BIT = MASK_DIM'(1);

  spc_pkg::spc_state_e state_q, state_d;
  spc_pkg::spc_ctl_t ctl;
  logic scan_last;
  logic out_free;

  logic [MASK_DIM-1:0] mask_a_q [MASK_DIM];
  logic [MASK_DIM-1:0] mask_b_q [MASK_DIM];

  logic [LOC_W-1:0] arow_q, brow_q, acol_q, bcol_q, ncols_q, left_q;
  logic touch_q, found_q;
  logic [COUNT_W-1:0] count_q;
  logic [COORD_W-1:0] fac_q, far_q, fbc_q, fbr_q;

  logic out_valid_q;
  spc_pkg::spc_res_t out_q;

  assign out_free = !out_valid_q || res_ready_i;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      spc_pkg::ST_IDLE: begin
        if (cmd_valid_i && cmd_i.op == spc_pkg::OP_QUERY) begin
          state_d = cmd_i.touch ? spc_pkg::ST_SCAN : spc_pkg::ST_DONE;
        end
      end
      spc_pkg::ST_SCAN: begin
        if (scan_last) begin
          state_d = spc_pkg::ST_DONE;
        end
      end
      spc_pkg::ST_DONE: begin
        if (out_free) begin
          state_d = spc_pkg::ST_IDLE;
        end
      end
      default: state_d = spc_pkg::ST_IDLE;
    endcase
  end

  // control strobes
  always_comb begin
    ctl = '0;
    case (state_q)
      spc_pkg::ST_IDLE: begin
        ctl.pop = cmd_valid_i;
        ctl.mask_we = cmd_valid_i && cmd_i.op == spc_pkg::OP_LOAD;
        ctl.start = cmd_valid_i && cmd_i.op == spc_pkg::OP_QUERY;
      end
      spc_pkg::ST_SCAN: ctl.step = 1'b1;
      spc_pkg::ST_DONE: ctl.emit = out_free;
      default: ctl = '0;
    endcase
  end

  assign cmd_pop_o = ctl.pop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= spc_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // mask row writes
  logic row_ok;
  assign row_ok = (LOC_W'(cmd_i.row) < DIM);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MASK_DIM; i++) begin
        mask_a_q[i] <= '0;
        mask_b_q[i] <= '0;
      end
    end else if (ctl.mask_we && row_ok) begin
      if (cmd_i.sel == spc_pkg::SEL_A) begin
        mask_a_q[cmd_i.row[IW-1:0]] <= cmd_i.bits[MASK_DIM-1:0];
      end else begin
        mask_b_q[cmd_i.row[IW-1:0]] <= cmd_i.bits[MASK_DIM-1:0];
      end
    end
  end

  // one overlap row: align both rows, clip to the overlap width
  logic [MASK_DIM-1:0] row_a, row_b, col_mask, hits;
  logic [PC_W-1:0] pc;
  logic [IW-1:0] hit_idx;
  logic [LOC_W-1:0] hit_ac, hit_bc;

  always_comb begin
    row_a = (arow_q < DIM) ? mask_a_q[arow_q[IW-1:0]] : '0;
    row_b = (brow_q < DIM) ? mask_b_q[brow_q[IW-1:0]] : '0;
    col_mask = (ncols_q >= DIM) ? '1 : (ONE_BIT << ncols_q) - ONE_BIT;
    hits = (row_a >> acol_q) & (row_b >> bcol_q) & col_mask;
    pc = '0;
    for (int i = 0; i < MASK_DIM; i++) begin
      pc = pc + PC_W'(hits[i]);
    end
    // lowest set column is the first hit in scan order
    hit_idx = '0;
    for (int i = MASK_DIM - 1; i >= 0; i--) begin
      if (hits[i]) begin
        hit_idx = IW'(i);
      end
    end
    hit_ac = acol_q + LOC_W'(hit_idx);
    hit_bc = bcol_q + LOC_W'(hit_idx);
    scan_last = (left_q == LOC_W'(1)) || (arow_q >= LAST_ROW) || (brow_q >= LAST_ROW);
  end

  // scan registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_q <= 1'b0;
    end else if (ctl.start) begin
      found_q <= 1'b0;
    end else if (ctl.step && |hits) begin
      found_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl.start) begin
      arow_q <= cmd_i.a_row;
      brow_q <= cmd_i.b_row;
      acol_q <= cmd_i.a_col;
      bcol_q <= cmd_i.b_col;
      ncols_q <= cmd_i.n_cols;
      left_q <= cmd_i.n_rows;
      touch_q <= cmd_i.touch;
      count_q <= '0;
      fac_q <= '0;
      far_q <= '0;
      fbc_q <= '0;
      fbr_q <= '0;
    end else if (ctl.step) begin
      arow_q <= arow_q + LOC_W'(1);
      brow_q <= brow_q + LOC_W'(1);
      left_q <= left_q - LOC_W'(1);
      count_q <= count_q + COUNT_W'(pc);
      if (!found_q && |hits) begin
        fac_q <= hit_ac[COORD_W-1:0];
        far_q <= arow_q[COORD_W-1:0];
        fbc_q <= hit_bc[COORD_W-1:0];
        fbr_q <= brow_q[COORD_W-1:0];
      end
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctl.emit) begin
      out_valid_q <= 1'b1;
    end else if (res_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl.emit) begin
      out_q.is_collision <= found_q;
      out_q.bounds_touch <= touch_q;
      out_q.hit_count <= count_q;
      out_q.first_a_col <= fac_q;
      out_q.first_a_row <= far_q;
      out_q.first_b_col <= fbc_q;
      out_q.first_b_row <= fbr_q;
    end
  end

  assign res_valid_o = out_valid_q;
  assign res_o = out_q;

endmodule

// ===== design/sprite_pixel_collision.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sprite_pixel_collision - pixel-exact collision test of two sprite masks
// Loads mask rows and answers collision queries over a stream interface.
// ----------------------------------------------------------------------------
// Usage:
//   Slave channel: tuser selects the operation (bit 0: 0 load, 1 query) and,
//   for loads, the mask (bit 1). A load writes one mask row and gives no
//   result. A query gives both positions and returns one result transaction.
//   Configuration (origins and sizes) must be written through cfg_we_i/cfg_idx_i/
//   cfg_data_i only while no transaction is in flight; the block does not enforce it.
//   A load's mask row passes the input register and the command queue and is
//   written when the idle engine takes it. A query passes the same registers,
//   then the scan engine handles one overlap row pair per cycle (disjoint
//   boxes skip the scan), at most 16 rows with the mask store of 16 by 16
//   pixels, before the result goes to the output register; while a query is
//   in the engine, the next transaction waits behind it.
//   A two-entry command queue and an input register let loads and queries
//   keep arriving while the engine works or a result waits.
//   Reset clears both masks, origins to 0 and sizes to 16.
//   When the master side stalls, the result holds in the output register;
//   the engine stops before overwriting it and the queue fills behind it.
// ----------------------------------------------------------------------------
module sprite_pixel_collision #(
  parameter int unsigned SPRITE_SIZE = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  // configuration write port
  input  logic cfg_we_i,
  input  logic [2:0] cfg_idx_i,
  input  logic [4:0] cfg_data_i,
  // slave side
  input  logic s_tvalid_i,
  output logic s_tready_o,
  // row_index[3:0], row_bits[19:4], a_pos_x[35:20], a_pos_y[51:36],
  // b_pos_x[67:52], b_pos_y[83:68], zero[87:84]
  input  logic [87:0] s_tdata_i,
  // operation[0], sprite_select[1]
  input  logic [1:0] s_tuser_i,
  // master side
  output logic m_tvalid_o,
  input  logic m_tready_i,
  // is_collision[0], bounds_touch[1], hit_count[10:2], first_a_col[14:11],
  // first_a_row[18:15], first_b_col[22:19], first_b_row[26:23], zero[31:27]
  output logic [31:0] m_tdata_o
);

  spc_pkg::spc_cmd_t front_cmd, queue_cmd;
  logic front_valid, queue_ready, queue_valid, queue_pop;
  spc_pkg::spc_res_t res;

  spc_front #(
    .SPRITE_SIZE(SPRITE_SIZE)
  ) u_front (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .cfg_we_i(cfg_we_i),
    .cfg_idx_i(cfg_idx_i),
    .cfg_data_i(cfg_data_i),
    .s_tvalid_i(s_tvalid_i),
    .s_tready_o(s_tready_o),
    .s_tdata_i(s_tdata_i),
    .s_tuser_i(s_tuser_i),
    .cmd_valid_o(front_valid),
    .cmd_ready_i(queue_ready),
    .cmd_o(front_cmd)
  );

  spc_queue u_queue (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .push_valid_i(front_valid),
    .push_ready_o(queue_ready),
    .push_data_i(front_cmd),
    .pop_valid_o(queue_valid),
    .pop_i(queue_pop),
    .pop_data_o(queue_cmd)
  );

  spc_back #(
    .SPRITE_SIZE(SPRITE_SIZE)
  ) u_back (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .cmd_valid_i(queue_valid),
    .cmd_pop_o(queue_pop),
    .cmd_i(queue_cmd),
    .res_valid_o(m_tvalid_o),
    .res_ready_i(m_tready_i),
    .res_o(res)
  );

  // result packing, last struct field in the lowest bits
  assign m_tdata_o = {5'd0, res};

endmodule
